// ===== sv/dcchb_pkg.sv =====
// Shared types and constants for the DCC half-bit packet decoder.
// No dependencies.
package dcchb_pkg;

  localparam int CFG_TICK_W  = 15;
  localparam int CFG_DELTA_W = 8;
  localparam int CFG_PRE_W   = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_MIN  = 3'd0,
    REG_ONE_MIN   = 3'd1,
    REG_ONE_MAX   = 3'd2,
    REG_DELTA_MAX = 3'd3,
    REG_PRE_MIN   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_PROGRESS = 3'd0,
    EV_BADLEN   = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_DELTA    = 3'd3,
    EV_DATA     = 3'd4,
    EV_SEP      = 3'd5,
    EV_CHECKERR = 3'd6,
    EV_OK       = 3'd7
  } event_t;

  typedef struct packed {
    logic [CFG_TICK_W-1:0]  zero_min;
    logic [CFG_TICK_W-1:0]  one_min;
    logic [CFG_TICK_W-1:0]  one_max;
    logic [CFG_DELTA_W-1:0] delta_max;
    logic [CFG_PRE_W-1:0]   pre_min;
  } cfg_t;

  typedef struct packed {
    logic bad;
    logic one;
  } half_class_t;

  localparam int CLASS_W = $bits(half_class_t);

  localparam logic [CFG_TICK_W-1:0]  ZERO_MIN_RST  = 15'd180;
  localparam logic [CFG_TICK_W-1:0]  ONE_MIN_RST   = 15'd104;
  localparam logic [CFG_TICK_W-1:0]  ONE_MAX_RST   = 15'd128;
  localparam logic [CFG_DELTA_W-1:0] DELTA_MAX_RST = 8'd12;
  localparam logic [CFG_PRE_W-1:0]   PRE_MIN_RST   = 6'd20;

  localparam logic [CFG_PRE_W-1:0] PRE_COUNT_MAX = '1;
  localparam logic [7:0]           MSB_MASK      = 8'h80;

endpackage

// ===== sv/dcchb_classify.sv =====
// Front end: classes a half period as zero, one or bad length.
// Depends on dcchb_pkg.
module dcchb_classify import dcchb_pkg::*; #(
  parameter int TICK_WIDTH = 15
) (
  input  logic [TICK_WIDTH-1:0] len,
  input  cfg_t                  cfg,
  output half_class_t           cls
);

  localparam int CW = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;

  logic [CW-1:0] len_x;
  logic          is_zero;
  logic          is_one;

  always_comb begin
    len_x   = CW'(len);
    is_zero = len_x >= CW'(cfg.zero_min);
    is_one  = (len_x >= CW'(cfg.one_min)) && (len_x <= CW'(cfg.one_max));
    cls.one = !is_zero && is_one;
    cls.bad = !is_zero && !is_one;
  end

endmodule

// ===== sv/dcchb_queue.sv =====
// Two-entry word queue between the classifier and the packet parser.
// Depends on nothing.
module dcchb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/dcchb_parse.sv =====
// Back end: preamble hunt, bit pairing, byte assembly and check, with output register.
// Depends on dcchb_pkg.
module dcchb_parse import dcchb_pkg::*; #(
  parameter int TICK_WIDTH = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  word_avail,
  input  logic [TICK_WIDTH-1:0] word_len,
  input  half_class_t           word_cls,
  output logic                  word_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            event_code,
  output logic                  bit_value,
  output logic [7:0]            data_byte,
  output logic                  packet_good
);

  localparam int DW = (TICK_WIDTH > CFG_DELTA_W) ? TICK_WIDTH : CFG_DELTA_W;

  typedef enum logic [1:0] {
    SEEK   = 2'd0,
    START  = 2'd1,
    FIRST  = 2'd2,
    SECOND = 2'd3
  } phase_t;

  phase_t                phase, phase_next;
  logic [CFG_PRE_W-1:0]  pre_count, pre_count_next;
  logic                  first_bit, first_bit_next;
  logic [TICK_WIDTH-1:0] first_len, first_len_next;
  logic [7:0]            bit_mask, bit_mask_next;
  logic [7:0]            asm_byte, asm_byte_next;
  logic [7:0]            check, check_next;
  event_t                ev;
  logic                  good;
  logic [TICK_WIDTH-1:0] diff;
  logic                  b;

  assign word_take = word_avail && (!out_valid || out_ready);

  always_comb begin
    phase_next     = phase;
    pre_count_next = pre_count;
    first_bit_next = first_bit;
    first_len_next = first_len;
    bit_mask_next  = bit_mask;
    asm_byte_next  = asm_byte;
    check_next     = check;
    ev             = EV_PROGRESS;
    good           = 1'b0;
    b              = word_cls.one;
    diff           = (word_len > first_len) ? word_len - first_len : first_len - word_len;
    if (word_cls.bad) begin
      phase_next     = SEEK;
      pre_count_next = '0;
      ev             = EV_BADLEN;
    end else begin
      unique case (phase)
        SEEK: begin
          if (b) begin
            if (pre_count != PRE_COUNT_MAX) begin
              pre_count_next = pre_count + 1'b1;
            end
          end else if (pre_count >= cfg.pre_min) begin
            phase_next = START;
          end else begin
            pre_count_next = '0;
          end
        end
        START: begin
          if (b) begin
            phase_next     = SEEK;
            pre_count_next = '0;
            ev             = EV_MISMATCH;
          end else begin
            bit_mask_next = MSB_MASK;
            check_next    = '0;
            phase_next    = FIRST;
          end
        end
        FIRST: begin
          first_bit_next = b;
          first_len_next = word_len;
          phase_next     = SECOND;
        end
        SECOND: begin
          priority if (first_bit != b) begin
            phase_next     = SEEK;
            pre_count_next = '0;
            ev             = EV_MISMATCH;
          end else if (b && (DW'(diff) > DW'(cfg.delta_max))) begin
            phase_next     = SEEK;
            pre_count_next = '0;
            ev             = EV_DELTA;
          end else if (bit_mask != 8'd0) begin
            asm_byte_next = b ? (asm_byte | bit_mask) : (asm_byte & ~bit_mask);
            bit_mask_next = bit_mask >> 1;
            phase_next    = FIRST;
            ev            = EV_DATA;
          end else if (!b) begin
            check_next    = check ^ asm_byte;
            bit_mask_next = MSB_MASK;
            phase_next    = FIRST;
            ev            = EV_SEP;
          end else if (asm_byte != check) begin
            phase_next     = SEEK;
            pre_count_next = '0;
            ev             = EV_CHECKERR;
          end else begin
            phase_next     = SEEK;
            pre_count_next = '0;
            ev             = EV_OK;
            good           = 1'b1;
          end
        end
        default: phase_next = SEEK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= SEEK;
      pre_count   <= '0;
      first_bit   <= 1'b0;
      first_len   <= '0;
      bit_mask    <= '0;
      asm_byte    <= '0;
      check       <= '0;
      out_valid   <= 1'b0;
      event_code  <= EV_PROGRESS;
      bit_value   <= 1'b0;
      data_byte   <= '0;
      packet_good <= 1'b0;
    end else begin
      if (word_take) begin
        phase       <= phase_next;
        pre_count   <= pre_count_next;
        first_bit   <= first_bit_next;
        first_len   <= first_len_next;
        bit_mask    <= bit_mask_next;
        asm_byte    <= asm_byte_next;
        check       <= check_next;
        out_valid   <= 1'b1;
        event_code  <= ev;
        bit_value   <= b;
        data_byte   <= asm_byte_next;
        packet_good <= good;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/dcc_half_bit_packet_decoder.sv =====
// DCC half-bit packet decoder, top level: config registers, classifier, queue, parser.
// A word is classified and written into the queue when accepted, then parsed from the queue
// into the output register. The parser takes one word per cycle unless the output register
// holds a result and out_ready is low.
// Reset (rst, synchronous, active high): config to defaults, parser to preamble hunt,
// queue and output register empty.
// Depends on dcchb_pkg, dcchb_classify, dcchb_queue, dcchb_parse.
module dcc_half_bit_packet_decoder import dcchb_pkg::*; #(
  parameter int TICK_WIDTH = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TICK_WIDTH-1:0] half_period_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            event_code,
  output logic                  bit_value,
  output logic [7:0]            data_byte,
  output logic                  packet_good
);

  localparam int QW = TICK_WIDTH + CLASS_W;

  cfg_t                  cfg;
  half_class_t           in_cls;
  half_class_t           q_cls;
  logic [TICK_WIDTH-1:0] q_len;
  logic [QW-1:0]         q_data;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic                  push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_min  <= ZERO_MIN_RST;
      cfg.one_min   <= ONE_MIN_RST;
      cfg.one_max   <= ONE_MAX_RST;
      cfg.delta_max <= DELTA_MAX_RST;
      cfg.pre_min   <= PRE_MIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ZERO_MIN:  cfg.zero_min  <= cfg_wdata;
        REG_ONE_MIN:   cfg.one_min   <= cfg_wdata;
        REG_ONE_MAX:   cfg.one_max   <= cfg_wdata;
        REG_DELTA_MAX: cfg.delta_max <= cfg_wdata[CFG_DELTA_W-1:0];
        REG_PRE_MIN:   cfg.pre_min   <= cfg_wdata[CFG_PRE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  dcchb_classify #(.TICK_WIDTH(TICK_WIDTH)) u_classify (
    .len (half_period_ticks),
    .cfg (cfg),
    .cls (in_cls)
  );

  dcchb_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({half_period_ticks, in_cls}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  assign q_len = q_data[QW-1:CLASS_W];
  assign q_cls = q_data[CLASS_W-1:0];

  dcchb_parse #(.TICK_WIDTH(TICK_WIDTH)) u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .word_avail  (!q_empty),
    .word_len    (q_len),
    .word_cls    (q_cls),
    .word_take   (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_code  (event_code),
    .bit_value   (bit_value),
    .data_byte   (data_byte),
    .packet_good (packet_good)
  );

endmodule
